FILE: sv/gcdist_pkg.sv
package gcdist_pkg;

  localparam int unsigned TrigIterations = 32;
  localparam int unsigned CordicW = 34;
  localparam int unsigned SqrtSteps = 31;

  localparam logic [23:0] RadiusReset = 24'd6378388;
  localparam logic [28:0] MicrodegPerTurn = 29'd360000000;
  localparam logic [19:0] DivDenom = 20'd703125;
  localparam logic [22:0] DivRound = 23'd351562;
  localparam logic [32:0] DivRecip = 33'd6405119470;
  localparam logic [29:0] CordicGain = 30'd652032874;
  localparam logic [23:0] TwoPiQ21 = 24'd13176795;
  localparam logic [25:0] DistMax = 26'd52705302;

  function automatic logic [29:0] gcdist_atan(input int idx);
    logic [29:0] v;
    unique case (idx)
      0: v = 30'd536870912;
      1: v = 30'd316933406;
      2: v = 30'd167458907;
      3: v = 30'd85004756;
      4: v = 30'd42667331;
      5: v = 30'd21354465;
      6: v = 30'd10680862;
      7: v = 30'd5340245;
      8: v = 30'd2670163;
      9: v = 30'd1335087;
      10: v = 30'd667544;
      11: v = 30'd333772;
      12: v = 30'd166886;
      13: v = 30'd83443;
      14: v = 30'd41722;
      15: v = 30'd20861;
      16: v = 30'd10430;
      17: v = 30'd5215;
      18: v = 30'd2608;
      19: v = 30'd1304;
      20: v = 30'd652;
      21: v = 30'd326;
      22: v = 30'd163;
      23: v = 30'd81;
      24: v = 30'd41;
      25: v = 30'd20;
      26: v = 30'd10;
      27: v = 30'd5;
      28: v = 30'd3;
      29: v = 30'd1;
      30: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

FILE: sv/gcdist_div_cell.sv
module gcdist_div_cell (
  input  logic        clk_i,
  input  logic [28:0] m_i,
  output logic [31:0] ang_o
);
  import gcdist_pkg::*;

  logic [61:0] prod;
  logic [51:0] num, back, rem;
  logic [31:0] qa_q, qb_q;
  logic [28:0] m_q;
  logic [20:0] r_q;

  assign prod = 62'(m_i) * 62'(DivRecip);
  assign num = {m_q, DivRound};
  assign back = 52'(qa_q) * 52'(DivDenom);
  assign rem = num - back;

  always_ff @(posedge clk_i) begin
    qa_q <= prod[60:29];
    m_q <= m_i;
    qb_q <= qa_q;
    r_q <= rem[20:0];
  end

  assign ang_o = qb_q + 32'(r_q >= {1'b0, DivDenom});
endmodule

FILE: sv/gcdist_cordic_cell.sv
module gcdist_cordic_cell #(
  parameter int unsigned I   = 0,
  parameter bit          VEC = 1'b0,
  parameter int unsigned W   = gcdist_pkg::CordicW,
  parameter int unsigned SW  = 1
) (
  input  logic                clk_i,
  input  logic signed [W-1:0] x_i,
  input  logic signed [W-1:0] y_i,
  input  logic signed [W-1:0] z_i,
  input  logic [SW-1:0]       side_i,
  output logic signed [W-1:0] x_o,
  output logic signed [W-1:0] y_o,
  output logic signed [W-1:0] z_o,
  output logic [SW-1:0]       side_o
);
  import gcdist_pkg::*;

  localparam logic signed [W-1:0] Atan = W'(gcdist_atan(I));

  logic signed [W-1:0] dx, dy, x_d, y_d, z_d, x_q, y_q, z_q;
  logic [SW-1:0] side_q;
  logic sigma;

  always_comb begin
    dx = y_i >>> I;
    dy = x_i >>> I;
    sigma = VEC ? y_i[W-1] : !z_i[W-1];
    if (sigma) begin
      x_d = x_i - dx;
      y_d = y_i + dy;
      z_d = z_i - Atan;
    end else begin
      x_d = x_i + dx;
      y_d = y_i - dy;
      z_d = z_i + Atan;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
    side_q <= side_i;
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;
  assign side_o = side_q;
endmodule

FILE: sv/gcdist_sqrt_cell.sv
module gcdist_sqrt_cell #(
  parameter int unsigned K = 0
) (
  input  logic        clk_i,
  input  logic [61:0] r_i,
  input  logic [30:0] q_i,
  input  logic [31:0] side_i,
  output logic [61:0] r_o,
  output logic [30:0] q_o,
  output logic [31:0] side_o
);
  logic [61:0] trial, r_d, r_q;
  logic [30:0] q_d, q_q;
  logic [31:0] side_q;

  always_comb begin
    trial = (62'(q_i) << (K + 1)) + (62'(1) << (2 * K));
    if (r_i >= trial) begin
      r_d = r_i - trial;
      q_d = q_i | (31'(1) << K);
    end else begin
      r_d = r_i;
      q_d = q_i;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d;
    q_q <= q_d;
    side_q <= side_i;
  end

  assign r_o = r_q;
  assign q_o = q_q;
  assign side_o = side_q;
endmodule

FILE: sv/great_circle_distance.sv
// Great-circle distance by the spherical law of cosines. A point pair is
// taken at every clock edge with start_i high (busy_o stays low, so a new
// pair may follow in every cycle). Its distance in meters appears on
// distance_m_o with done_o high for exactly one cycle; results leave in
// input order and the receiver cannot stall them. The pipeline is a chain
// of cells: two stages that turn microdegrees into binary angles by a
// reciprocal multiply and one correcting compare, one CORDIC cell per
// iteration for sine and cosine, 31 square-root cells, one CORDIC cell per
// iteration for the arc cosine, and nine stages of multiplies and
// bookkeeping. Write the sphere radius only while no pair is in flight.
module great_circle_distance #(
  parameter int unsigned TRIG_ITERATIONS = gcdist_pkg::TrigIterations
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        cfg_we_i,
  input  logic [23:0] cfg_wdata_i,
  input  logic signed [27:0] lat_first_i,
  input  logic signed [28:0] lon_first_i,
  input  logic signed [27:0] lat_second_i,
  input  logic signed [28:0] lon_second_i,
  output logic        done_o,
  output logic [25:0] distance_m_o
);
  import gcdist_pkg::*;

  localparam int unsigned N = TRIG_ITERATIONS;
  localparam int unsigned W = CordicW;
  localparam int unsigned Lat = 42 + 2 * N;

  logic [23:0] radius_q;
  logic [Lat-1:0] valid_q;
  logic accept;

  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RadiusReset;
      valid_q <= '0;
    end else begin
      if (cfg_we_i) radius_q <= cfg_wdata_i;
      valid_q <= {valid_q[Lat-2:0], accept};
    end
  end

  // Reduce to one turn and convert to binary angles.
  logic signed [29:0] md [4];
  logic [28:0] m [4];
  logic [31:0] bang [4];

  always_comb begin
    md[0] = 30'(lat_first_i);
    md[1] = 30'(lon_first_i);
    md[2] = 30'(lat_second_i);
    md[3] = 30'(lon_second_i);
    for (int k = 0; k < 4; k++) begin
      m[k] = md[k][29] ? 29'(md[k] + $signed({1'b0, MicrodegPerTurn})) : md[k][28:0];
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_div
    gcdist_div_cell u_cell (
      .clk_i (clk_i),
      .m_i   (m[k]),
      .ang_o (bang[k])
    );
  end

  // Rotation CORDIC rows: latitude one, latitude two, longitude difference.
  logic [31:0] ang [3];
  logic signed [W-1:0] rx [3][N+1];
  logic signed [W-1:0] ry [3][N+1];
  logic signed [W-1:0] rz [3][N+1];
  logic [1:0] rs [3][N+1];

  always_comb begin
    ang[0] = bang[0];
    ang[1] = bang[2];
    ang[2] = bang[3] - bang[1];
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      rx[k][0] <= W'(CordicGain);
      ry[k][0] <= '0;
      rz[k][0] <= W'(ang[k][29:0]);
      rs[k][0] <= ang[k][31:30];
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_rot
    for (genvar j = 0; j < N; j++) begin : g_cell
      gcdist_cordic_cell #(.I(j), .VEC(1'b0), .W(W), .SW(2)) u_cell (
        .clk_i  (clk_i),
        .x_i    (rx[k][j]),
        .y_i    (ry[k][j]),
        .z_i    (rz[k][j]),
        .side_i (rs[k][j]),
        .x_o    (rx[k][j+1]),
        .y_o    (ry[k][j+1]),
        .z_o    (rz[k][j+1]),
        .side_o (rs[k][j+1])
      );
    end
  end

  logic signed [W-1:0] cv [3];
  logic signed [W-1:0] sv [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      unique case (rs[k][N])
        2'd0: begin cv[k] = rx[k][N];  sv[k] = ry[k][N];  end
        2'd1: begin cv[k] = -ry[k][N]; sv[k] = rx[k][N];  end
        2'd2: begin cv[k] = -rx[k][N]; sv[k] = -ry[k][N]; end
        default: begin cv[k] = ry[k][N]; sv[k] = -rx[k][N]; end
      endcase
    end
  end

  // Cosine sum.
  logic signed [2*W-1:0] p1, p2;
  logic signed [35:0] t1_q, t2_q, t1b_q, t3_q;
  logic signed [W-1:0] cl_q;
  logic signed [W+35:0] p3;
  logic signed [36:0] sum;
  logic [30:0] a_q, a2_q;
  logic neg_q, neg2_q;
  logic [61:0] n_q;

  assign p1 = sv[0] * sv[1];
  assign p2 = cv[0] * cv[1];
  assign p3 = t2_q * cl_q;
  assign sum = 37'(t1b_q) + 37'(t3_q);

  always_ff @(posedge clk_i) begin
    t1_q <= p1[65:30];
    t2_q <= p2[65:30];
    cl_q <= cv[2];
    t1b_q <= t1_q;
    t3_q <= p3[65:30];
    neg_q <= sum[36];
    priority if (sum > 37'sd1073741824) a_q <= 31'd1073741824;
    else if (sum < -37'sd1073741824) a_q <= 31'd1073741824;
    else if (sum[36]) a_q <= 31'(-sum);
    else a_q <= sum[30:0];
    n_q <= (62'(1) << 60) - 62'(a_q) * 62'(a_q);
    a2_q <= a_q;
    neg2_q <= neg_q;
  end

  // Integer square root.
  logic [61:0] sr [SqrtSteps+1];
  logic [30:0] sq [SqrtSteps+1];
  logic [31:0] ss [SqrtSteps+1];

  assign sr[0] = n_q;
  assign sq[0] = '0;
  assign ss[0] = {neg2_q, a2_q};

  for (genvar j = 0; j < SqrtSteps; j++) begin : g_sqrt
    gcdist_sqrt_cell #(.K(SqrtSteps - 1 - j)) u_cell (
      .clk_i  (clk_i),
      .r_i    (sr[j]),
      .q_i    (sq[j]),
      .side_i (ss[j]),
      .r_o    (sr[j+1]),
      .q_o    (sq[j+1]),
      .side_o (ss[j+1])
    );
  end

  // Vectoring CORDIC for the arc cosine.
  logic signed [W-1:0] vx [N+1];
  logic signed [W-1:0] vy [N+1];
  logic signed [W-1:0] vz [N+1];
  logic vs [N+1];

  assign vx[0] = W'(ss[SqrtSteps][30:0]);
  assign vy[0] = W'(sq[SqrtSteps]);
  assign vz[0] = '0;
  assign vs[0] = ss[SqrtSteps][31];

  for (genvar j = 0; j < N; j++) begin : g_vec
    gcdist_cordic_cell #(.I(j), .VEC(1'b1), .W(W), .SW(1)) u_cell (
      .clk_i  (clk_i),
      .x_i    (vx[j]),
      .y_i    (vy[j]),
      .z_i    (vz[j]),
      .side_i (vs[j]),
      .x_o    (vx[j+1]),
      .y_o    (vy[j+1]),
      .z_o    (vz[j+1]),
      .side_o (vs[j+1])
    );
  end

  // Central angle to meters.
  logic [30:0] zc;
  logic [31:0] ang_q;
  logic [39:0] hi_q;
  logic [64:0] dm;
  logic [27:0] dist_q;
  logic [55:0] rprod;
  logic [25:0] dist_out_q;

  always_comb begin
    priority if (vz[N][W-1]) zc = '0;
    else if (vz[N] > W'(1073741824)) zc = 31'd1073741824;
    else zc = vz[N][30:0];
  end

  assign rprod = 56'(radius_q) * 56'(ang_q);
  assign dm = 65'(hi_q) * 65'(TwoPiQ21) + (65'(1) << 36);

  always_ff @(posedge clk_i) begin
    ang_q <= vs[N] ? 32'((33'(1) << 31) - 33'(zc)) : 32'(zc);
    hi_q <= rprod[55:16];
    dist_q <= dm[64:37];
    dist_out_q <= (dist_q > 28'(DistMax)) ? DistMax : dist_q[25:0];
  end

  assign done_o = valid_q[Lat-1];
  assign distance_m_o = dist_out_q;
endmodule

FILE: sv/gcdist_checker.sv
module gcdist_checker #(
  parameter int unsigned TRIG_ITERATIONS = gcdist_pkg::TrigIterations
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        done_o,
  input logic [25:0] distance_m_o
);
  import gcdist_pkg::*;

  localparam int unsigned Lat = 42 + 2 * TRIG_ITERATIONS;

  a_dist_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> distance_m_o <= DistMax)
    else $error("distance above maximum");

  a_done_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##Lat done_o)
    else $error("transfer lost");

  a_no_spurious_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, Lat))
    else $error("result without transfer");
endmodule

bind great_circle_distance gcdist_checker #(.TRIG_ITERATIONS(TRIG_ITERATIONS)) u_gcdist_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start_i      (start_i),
  .busy_o       (busy_o),
  .done_o       (done_o),
  .distance_m_o (distance_m_o)
);
